>>> hw/rtl/scrt_pkg.sv
// Shared types, codes and constants of the sensor change report trigger.
`default_nettype none

package scrt_pkg;

  // Default number of tracked devices
  localparam int DEVICES_DEF = 16;

  // Depth of the decision queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Stream widths
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_TEMP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_HUM       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_DRIFT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUMIDITY_DRIFT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF        = 3'd5;

  // Register values after reset
  localparam logic               ENABLE_RST         = 1'b1;
  localparam logic signed [15:0] WARN_TEMP_RST      = 16'sd3000;
  localparam logic signed [15:0] WARN_HUM_RST       = 16'sd7000;
  localparam logic [14:0]        TEMP_DRIFT_RST     = 15'd100;
  localparam logic [14:0]        HUMIDITY_DRIFT_RST = 15'd500;
  localparam logic [15:0]        HOLDOFF_RST        = 16'd60;

  // Report reasons
  typedef enum logic [2:0] {
    REASON_SILENT  = 3'd0,
    REASON_FIRST   = 3'd1,
    REASON_ANOMALY = 3'd2,
    REASON_ROSE    = 3'd3,
    REASON_FELL    = 3'd4,
    REASON_DRIFT   = 3'd5
  } reason_t;

  // Batch-end decision passed from front to back
  typedef struct packed {
    logic [3:0]  dev;
    reason_t     reason;
    logic        cross_kind;
    logic        drift_kind;
    logic [15:0] drift_amount;
  } decision_t;

endpackage

`default_nettype wire

>>> hw/rtl/scrt_front.sv
// Front: accepts readings, tracks per-device band and baseline state, decides at batch end.
`default_nettype none

module scrt_front #(
  parameter int DEVICES = scrt_pkg::DEVICES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [scrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scrt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [3:0]                     device,
  input  logic [1:0]                     sensor_kind,
  input  logic signed [15:0]             reading,
  input  logic                           anomaly,
  input  logic [31:0]                    now_seconds,
  input  logic                           last_in_batch,
  output logic                           push,
  output scrt_pkg::decision_t            push_data,
  input  logic                           queue_full
);
  import scrt_pkg::*;

  localparam int IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;

  // Configuration registers
  logic               enable;
  logic signed [15:0] warn_temp;
  logic signed [15:0] warn_hum;
  logic [14:0]        temp_drift_limit;
  logic [14:0]        humidity_drift_limit;
  logic [15:0]        holdoff_seconds;

  // Per-device state
  logic               reported     [DEVICES];
  logic [1:0]         in_band      [DEVICES];
  logic [1:0]         base_valid   [DEVICES];
  logic [31:0]        report_time  [DEVICES];
  logic signed [15:0] base_val     [DEVICES][2];

  // Open batch scratch
  logic               scr_open;
  logic [3:0]         scr_dev;
  logic               scr_crossed;
  logic               scr_cross_kind;
  logic               scr_cross_rose;
  logic               scr_drift_hit;
  logic               scr_drift_kind;
  logic [15:0]        scr_drift_amount;
  logic [1:0]         scr_seen;
  logic signed [15:0] scr_last_val [2];

  logic               accept;
  logic [3:0]         dev_cur;
  logic               dev_ok;
  logic [IDX_W-1:0]   idx;
  logic               k;
  logic               item_active;
  logic signed [15:0] band;
  logic [14:0]        thr;
  logic               was;
  logic               dev_rep;
  logic signed [18:0] val_x2;
  logic signed [18:0] hyst_lim;
  logic               in_band_now;
  logic signed [15:0] bv;
  logic signed [16:0] diff;
  logic [16:0]        mag;
  logic               drift_ge;
  logic               cross_new;
  logic               drift_new;
  logic               crossed_next;
  logic               cross_kind_next;
  logic               cross_rose_next;
  logic               drift_hit_next;
  logic               drift_kind_next;
  logic [15:0]        drift_amount_next;
  logic [1:0]         seen_next;
  logic signed [15:0] last_val_next [2];
  reason_t            reason_pre;
  reason_t            reason_fin;
  logic [31:0]        elapsed;
  logic               held;
  logic               batch_end;
  logic               report;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // Device of the batch comes from its first reading
  assign dev_cur     = scr_open ? scr_dev : device;
  assign dev_ok      = {28'd0, dev_cur} < 32'(DEVICES);
  assign idx         = IDX_W'(dev_cur);
  assign k           = sensor_kind[0];
  assign item_active = dev_ok && !sensor_kind[1];

  // Band test with hysteresis of half the drift limit (compared at twice scale)
  assign band        = k ? warn_hum : warn_temp;
  assign thr         = k ? humidity_drift_limit : temp_drift_limit;
  assign was         = in_band[idx][k];
  assign dev_rep     = reported[idx];
  assign val_x2      = {{2{reading[15]}}, reading, 1'b0};
  assign hyst_lim    = $signed({{2{band[15]}}, band, 1'b0}) - $signed({4'd0, thr});
  assign in_band_now = was ? (val_x2 > hyst_lim) : (reading > band);

  // Drift magnitude against the batch-start baseline
  assign bv       = base_val[idx][k];
  assign diff     = $signed({reading[15], reading}) - $signed({bv[15], bv});
  assign mag      = diff[16] ? 17'(-diff) : 17'(diff);
  assign drift_ge = mag[15:0] >= {1'b0, thr};

  assign cross_new = item_active && dev_rep && (in_band_now != was);
  assign drift_new = item_active && !(scr_open && scr_drift_hit) && dev_rep &&
                     base_valid[idx][k] && drift_ge;

  // Scratch as it stands after this reading; a closed batch starts from clear
  always_comb begin
    crossed_next      = scr_open && scr_crossed;
    cross_kind_next   = scr_open && scr_cross_kind;
    cross_rose_next   = scr_open && scr_cross_rose;
    drift_hit_next    = scr_open && scr_drift_hit;
    drift_kind_next   = scr_open && scr_drift_kind;
    drift_amount_next = scr_open ? scr_drift_amount : 16'd0;
    seen_next         = scr_open ? scr_seen : 2'b00;
    last_val_next[0]  = scr_last_val[0];
    last_val_next[1]  = scr_last_val[1];
    if (cross_new) begin
      crossed_next    = 1'b1;
      cross_kind_next = k;
      cross_rose_next = in_band_now;
    end
    if (drift_new) begin
      drift_hit_next    = 1'b1;
      drift_kind_next   = k;
      drift_amount_next = mag[15:0];
    end
    if (item_active) begin
      seen_next[k]     = 1'b1;
      last_val_next[k] = reading;
    end
  end

  // Reason by precedence, then holdoff on anomaly and drift
  always_comb begin
    if (!dev_rep) begin
      reason_pre = REASON_FIRST;
    end else if (crossed_next) begin
      reason_pre = cross_rose_next ? REASON_ROSE : REASON_FELL;
    end else if (anomaly) begin
      reason_pre = REASON_ANOMALY;
    end else if (drift_hit_next) begin
      reason_pre = REASON_DRIFT;
    end else begin
      reason_pre = REASON_SILENT;
    end
  end

  assign elapsed    = now_seconds - report_time[idx];
  assign held       = elapsed < {16'd0, holdoff_seconds};
  assign reason_fin = ((reason_pre == REASON_ANOMALY || reason_pre == REASON_DRIFT) && held)
                      ? REASON_SILENT : reason_pre;

  assign batch_end = accept && enable && last_in_batch && dev_ok;
  assign report    = batch_end && (reason_fin != REASON_SILENT);

  assign push = batch_end;
  always_comb begin
    push_data.dev          = dev_cur;
    push_data.reason       = reason_fin;
    push_data.cross_kind   = cross_kind_next;
    push_data.drift_kind   = drift_kind_next;
    push_data.drift_amount = drift_amount_next;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable               <= ENABLE_RST;
      warn_temp            <= WARN_TEMP_RST;
      warn_hum             <= WARN_HUM_RST;
      temp_drift_limit     <= TEMP_DRIFT_RST;
      humidity_drift_limit <= HUMIDITY_DRIFT_RST;
      holdoff_seconds      <= HOLDOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:         enable               <= cfg_data[0];
        REG_WARN_TEMP:      warn_temp            <= cfg_data;
        REG_WARN_HUM:       warn_hum             <= cfg_data;
        REG_TEMP_DRIFT:     temp_drift_limit     <= cfg_data[14:0];
        REG_HUMIDITY_DRIFT: humidity_drift_limit <= cfg_data[14:0];
        REG_HOLDOFF:        holdoff_seconds      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Batch scratch: open flag is control, the rest is qualified by it
  always_ff @(posedge clk) begin
    if (rst) begin
      scr_open <= 1'b0;
    end else if (accept) begin
      if (!enable || last_in_batch) begin
        scr_open <= 1'b0;
      end else begin
        scr_open <= 1'b1;
      end
    end
    if (accept && enable && !last_in_batch) begin
      scr_dev          <= dev_cur;
      scr_crossed      <= crossed_next;
      scr_cross_kind   <= cross_kind_next;
      scr_cross_rose   <= cross_rose_next;
      scr_drift_hit    <= drift_hit_next;
      scr_drift_kind   <= drift_kind_next;
      scr_drift_amount <= drift_amount_next;
      scr_seen         <= seen_next;
      scr_last_val[0]  <= last_val_next[0];
      scr_last_val[1]  <= last_val_next[1];
    end
  end

  // Per-device flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEVICES; i++) begin
        reported[i]   <= 1'b0;
        in_band[i]    <= 2'b00;
        base_valid[i] <= 2'b00;
      end
    end else begin
      if (accept && enable && item_active) begin
        in_band[idx][k] <= in_band_now;
      end
      if (report) begin
        reported[idx]   <= 1'b1;
        base_valid[idx] <= base_valid[idx] | seen_next;
      end
    end
  end

  // Report time and baselines, written on a report
  always_ff @(posedge clk) begin
    if (report) begin
      report_time[idx] <= now_seconds;
      for (int j = 0; j < 2; j++) begin
        if (seen_next[j]) begin
          base_val[idx][j] <= last_val_next[j];
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/scrt_queue.sv
// Short decision queue between the front and the back.
`default_nettype none

module scrt_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  scrt_pkg::decision_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                nonempty,
  output scrt_pkg::decision_t pop_data
);
  import scrt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  decision_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = count == CNT_W'(QUEUE_DEPTH);
  assign nonempty = count != '0;
  assign pop_data = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/scrt_back.sv
// Back: formats decisions into result requests and holds the output register.
`default_nettype none

module scrt_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_nonempty,
  input  scrt_pkg::decision_t                q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [scrt_pkg::OUT_TDATA_W-1:0]   out_data
);
  import scrt_pkg::*;

  logic        cause_kind;
  logic [15:0] cause_amount;

  // Cause fields only carry meaning for band and drift reasons
  always_comb begin
    cause_kind   = 1'b0;
    cause_amount = 16'd0;
    unique case (q_data.reason) inside
      REASON_ROSE, REASON_FELL: begin
        cause_kind = q_data.cross_kind;
      end
      REASON_DRIFT: begin
        cause_kind   = q_data.drift_kind;
        cause_amount = q_data.drift_amount;
      end
      default: ;
    endcase
  end

  assign q_pop = q_nonempty && (!out_valid || out_ready);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (q_pop) begin
      out_data <= {cause_amount, cause_kind, q_data.reason, q_data.dev};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sensor_change_report_trigger.sv
// A batch's last reading writes a decision queue entry, which then loads the output register.
// One reading per cycle while the decision queue is not full; each is classified against registered state.
// s_axis_tready drops only while both entries of the decision queue are occupied.
// Reset clears reported, band and baseline-valid flags, any open batch, the queue and the
// output register, and loads the register defaults; report times and baselines load on report.
`default_nettype none

module sensor_change_report_trigger #(
  parameter int DEVICES = scrt_pkg::DEVICES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [scrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scrt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // device[3:0], reading[19:4], anomaly[20], now_seconds[52:21], zero pad[55:53]
  input  logic [scrt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // sensor_kind[1:0]
  input  logic [scrt_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_device[3:0], report_reason[6:4], cause_kind[7], cause_amount[23:8]
  output logic [scrt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import scrt_pkg::*;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_nonempty;
  decision_t q_in;
  decision_t q_out;

  // Front: batch tracking and decision
  scrt_front #(
    .DEVICES(DEVICES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .device       (s_axis_tdata[3:0]),
    .sensor_kind  (s_axis_tuser[1:0]),
    .reading      (s_axis_tdata[19:4]),
    .anomaly      (s_axis_tdata[20]),
    .now_seconds  (s_axis_tdata[52:21]),
    .last_in_batch(s_axis_tlast),
    .push         (q_push),
    .push_data    (q_in),
    .queue_full   (q_full)
  );

  // Decision queue
  scrt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .pop_data (q_out)
  );

  // Back: result formatting and output register
  scrt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_nonempty(q_nonempty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  // Queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("decision queue overflow");

  // Queue never read while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_nonempty)
    else $error("decision queue underflow");

  // A nonzero amount only accompanies a drift reason
  a_amount_drift: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[23:8] != 16'd0)) |-> (m_axis_tdata[6:4] == REASON_DRIFT))
    else $error("cause amount set without drift reason");

  // A popped decision is presented in the output register in the next cycle
  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> m_axis_tvalid)
    else $error("popped decision not presented");

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the sensor change report trigger: stream stimulus and decision check.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import scrt_pkg::*;

  // Sensor kinds carried on s_axis_tuser
  localparam logic [1:0] KIND_TEMP  = 2'd0;
  localparam logic [1:0] KIND_HUM   = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int NUM_DEVS     = 16;
  localparam int QUIET_CYCLES = 4;
  localparam int HOLD_CYCLES  = 200;
  // ~610 readings, random idling on both sides, plus the long hold: far below this
  localparam int LIMIT_CYCLES = 200000;

  // One reading as it travels on the input stream
  typedef struct packed {
    logic [3:0]         dev;
    logic [1:0]         kind;
    logic signed [15:0] value;
    logic               anomaly;
    logic [31:0]        stamp;
    logic               last;
  } sample_t;

  // Expected batch-end decision
  typedef struct packed {
    logic [3:0]  dev;
    reason_t     why;
    logic        kind;
    logic [15:0] amount;
  } verdict_t;

  // Scratch of the batch being collected
  typedef struct packed {
    logic               open;
    logic [3:0]         dev;
    logic               crossed;
    logic               cross_kind;
    logic               cross_rose;
    logic               drift_hit;
    logic               drift_kind;
    logic [15:0]        drift_amt;
    logic [1:0]         seen;
    logic signed [15:0] last_t;
    logic signed [15:0] last_h;
  } batch_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // device[3:0], reading[19:4], anomaly[20], now_seconds[52:21], zero pad[55:53]
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // sensor_kind[1:0]
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // out_device[3:0], report_reason[6:4], cause_kind[7], cause_amount[23:8]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  sensor_change_report_trigger u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Predictor copy of the registers
  logic               cfg_en;
  logic signed [15:0] cfg_warn_t, cfg_warn_h;
  logic [14:0]        cfg_drift_t, cfg_drift_h;
  logic [15:0]        cfg_holdoff;

  // Predictor copy of the per-device state
  logic               rep_flag [NUM_DEVS];
  logic [31:0]        rep_time [NUM_DEVS];
  logic [1:0]         band_in  [NUM_DEVS];
  logic signed [15:0] base_val [NUM_DEVS][2];
  logic [1:0]         base_ok  [NUM_DEVS];
  batch_t             bat;

  sample_t  pending_q [$];
  verdict_t verdict_q [$];

  int pushed_cnt = 0;
  int sent_cnt   = 0;
  int errors     = 0;
  int cfg_changes = 0;
  int cycle_cnt  = 0;
  int tally [8];

  logic        s_took = 1'b0;
  logic        m_took = 1'b0;
  logic        hold_rx = 1'b0;
  logic        pressure_go = 1'b0;
  logic        tx_idle_on = 1'b1;
  logic        rx_idle_on = 1'b1;
  int          tx_wait = 0;
  int          rx_wait = 0;
  sample_t     tx_item;
  logic [31:0] clock_now = 32'd0;

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 40) $display("tb_top: mismatch: %s", msg);
  endtask

  // Predict the effect of one accepted reading; queue a decision at batch end
  task automatic track_reading(input sample_t s);
    int          v, band, thr, diff;
    logic        k, was, in_now;
    logic [3:0]  d;
    logic [31:0] elapsed;
    reason_t     why;
    verdict_t    want;
    if (!cfg_en) begin
      bat = '0;
      return;
    end
    if (!bat.open) begin
      bat = '0;
      bat.open = 1'b1;
      bat.dev = s.dev;
    end
    // 4-bit device index is always below the device count
    d = bat.dev;
    if (s.kind == KIND_TEMP || s.kind == KIND_HUM) begin
      k = s.kind[0];
      v = s.value;
      band = k ? cfg_warn_h : cfg_warn_t;
      thr = k ? cfg_drift_h : cfg_drift_t;
      was = band_in[d][k];
      // half-threshold hysteresis on the way out of the band
      in_now = was ? (2 * v > 2 * band - thr) : (v > band);
      if (rep_flag[d] && in_now != was) begin
        bat.crossed = 1'b1;
        bat.cross_kind = k;
        bat.cross_rose = in_now;
      end
      band_in[d][k] = in_now;
      // first drift against the baseline held at batch start
      if (!bat.drift_hit && rep_flag[d] && base_ok[d][k]) begin
        diff = v - base_val[d][k];
        if (diff < 0) diff = -diff;
        if (diff >= thr) begin
          bat.drift_hit = 1'b1;
          bat.drift_kind = k;
          bat.drift_amt = diff[15:0];
        end
      end
      if (k) bat.last_h = s.value;
      else bat.last_t = s.value;
      bat.seen[k] = 1'b1;
    end
    if (!s.last) return;

    if (!rep_flag[d]) why = REASON_FIRST;
    else if (bat.crossed) why = bat.cross_rose ? REASON_ROSE : REASON_FELL;
    else if (s.anomaly) why = REASON_ANOMALY;
    else if (bat.drift_hit) why = REASON_DRIFT;
    else why = REASON_SILENT;
    elapsed = s.stamp - rep_time[d];
    if ((why == REASON_ANOMALY || why == REASON_DRIFT) && elapsed < cfg_holdoff)
      why = REASON_SILENT;

    // a report moves the baseline of every kind seen
    if (why != REASON_SILENT) begin
      if (bat.seen[0]) begin
        base_val[d][0] = bat.last_t;
        base_ok[d][0] = 1'b1;
      end
      if (bat.seen[1]) begin
        base_val[d][1] = bat.last_h;
        base_ok[d][1] = 1'b1;
      end
      rep_time[d] = s.stamp;
      rep_flag[d] = 1'b1;
    end
    want.dev = d;
    want.why = why;
    want.kind = (why == REASON_ROSE || why == REASON_FELL) ? bat.cross_kind :
                (why == REASON_DRIFT) ? bat.drift_kind : 1'b0;
    want.amount = (why == REASON_DRIFT) ? bat.drift_amt : 16'd0;
    verdict_q = {verdict_q, want};
    bat = '0;
  endtask

  // Compare one output request with the oldest pending decision
  task automatic check_verdict(input logic [OUT_TDATA_W-1:0] word);
    verdict_t want;
    if (verdict_q.size() == 0) begin
      flag_error($sformatf("decision %h with none pending", word));
      return;
    end
    want = verdict_q[0];
    verdict_q.delete(0);
    tally[want.why]++;
    if (word[3:0] !== want.dev || word[6:4] !== want.why ||
        word[7] !== want.kind || word[23:8] !== want.amount)
      flag_error($sformatf("dev %0d/%0d reason %0d/%0d kind %0d/%0d amount %0d/%0d (got/want)",
                           word[3:0], want.dev, word[6:4], want.why,
                           word[7], want.kind, word[23:8], want.amount));
  endtask

  // Monitor: both handshakes, sampled at the rising edge
  always @(posedge clk) begin
    s_took = 1'b0;
    m_took = 1'b0;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_took = 1'b1;
        check_verdict(m_axis_tdata);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        s_took = 1'b1;
        sent_cnt++;
        track_reading('{dev: s_axis_tdata[3:0], kind: s_axis_tuser,
                        value: s_axis_tdata[19:4], anomaly: s_axis_tdata[20],
                        stamp: s_axis_tdata[52:21], last: s_axis_tlast});
      end
    end
  end

  // Driver: feeds the input stream from the pending queue
  always @(negedge clk) begin
    if (!s_axis_tvalid || s_took) begin
      if (tx_wait > 0) begin
        tx_wait = tx_wait - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        tx_item = pending_q[0];
        pending_q.delete(0);
        s_axis_tdata <= {3'b000, tx_item.stamp, tx_item.anomaly, tx_item.value, tx_item.dev};
        s_axis_tuser <= tx_item.kind;
        s_axis_tlast <= tx_item.last;
        s_axis_tvalid <= 1'b1;
        tx_wait = tx_idle_on ? $urandom_range(0, 4) : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random wait per result, plus the long hold
  always @(negedge clk) begin
    if (m_took) rx_wait = rx_idle_on ? $urandom_range(0, 4) : 0;
    if (hold_rx) begin
      m_axis_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait = rx_wait - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  // Watchdog
  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  task automatic push_sample(input sample_t s);
    pending_q = {pending_q, s};
    pushed_cnt++;
  endtask

  task automatic push_one(input logic [3:0] d, input logic [1:0] k,
                          input logic signed [15:0] v, input logic a,
                          input logic [31:0] t, input logic l);
    push_sample('{dev: d, kind: k, value: v, anomaly: a, stamp: t, last: l});
  endtask

  // Wait until every request is in and every decision is out
  task automatic wait_quiet();
    while (sent_cnt != pushed_cnt || verdict_q.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_ENABLE:         cfg_en = data[0];
      REG_WARN_TEMP:      cfg_warn_t = data;
      REG_WARN_HUM:       cfg_warn_h = data;
      REG_TEMP_DRIFT:     cfg_drift_t = data[14:0];
      REG_HUMIDITY_DRIFT: cfg_drift_h = data[14:0];
      REG_HOLDOFF:        cfg_holdoff = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic en, input logic [15:0] wt, input logic [15:0] wh,
                            input logic [14:0] dt, input logic [14:0] dh,
                            input logic [15:0] ho);
    wait_quiet();
    write_reg(REG_ENABLE, {15'd0, en});
    write_reg(REG_WARN_TEMP, wt);
    write_reg(REG_WARN_HUM, wh);
    write_reg(REG_TEMP_DRIFT, {1'b0, dt});
    write_reg(REG_HUMIDITY_DRIFT, {1'b0, dh});
    write_reg(REG_HOLDOFF, ho);
    cfg_changes++;
  endtask

  // Reading near the band of its kind, sometimes anywhere or at the rails
  function automatic logic signed [15:0] pick_value(input logic [1:0] k);
    int centre, spread, v;
    centre = k[0] ? cfg_warn_h : cfg_warn_t;
    spread = 2 * int'(k[0] ? cfg_drift_h : cfg_drift_t) + 16;
    case ($urandom_range(0, 9))
      0: v = int'($urandom_range(0, 65535)) - 32768;
      1: v = $urandom_range(0, 1) ? 32767 : -32768;
      default: v = centre + int'($urandom_range(0, 2 * spread)) - spread;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Random batches, mostly on a few devices so state builds up
  task automatic queue_batches(input int n, input int max_len);
    int         left, len, j;
    logic [3:0] d;
    sample_t    s;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 7) d = 4'($urandom_range(0, 3));
      else d = 4'($urandom_range(0, 15));
      len = $urandom_range(1, max_len);
      if (len > left) len = left;
      case ($urandom_range(0, 19))
        0:       clock_now = $urandom;
        1, 2:    clock_now = clock_now + $urandom_range(60, 70000);
        default: clock_now = clock_now + $urandom_range(0, 40);
      endcase
      for (j = 0; j < len; j++) begin
        s.dev = (j == 0) ? d : 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) == 0) s.kind = 2'($urandom_range(2, 3));
        else s.kind = 2'($urandom_range(0, 1));
        s.value = pick_value(s.kind);
        s.anomaly = ($urandom_range(0, 3) == 0);
        s.last = (j == len - 1);
        s.stamp = s.last ? clock_now : $urandom;
        push_sample(s);
      end
      left -= len;
    end
  endtask

  // Main sequence
  initial begin
    cfg_en = ENABLE_RST;
    cfg_warn_t = WARN_TEMP_RST;
    cfg_warn_h = WARN_HUM_RST;
    cfg_drift_t = TEMP_DRIFT_RST;
    cfg_drift_h = HUMIDITY_DRIFT_RST;
    cfg_holdoff = HOLDOFF_RST;
    bat = '0;
    for (int i = 0; i < NUM_DEVS; i++) begin
      rep_flag[i] = 1'b0;
      band_in[i] = 2'b00;
      base_ok[i] = 2'b00;
    end
    for (int i = 0; i < 8; i++) tally[i] = 0;
    rst = 1'b1;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed: first report, fall out of band, anomaly inside holdoff, drift, rise
    push_one(4'd0, KIND_TEMP, 16'sd32767, 1'b0, 32'd1000, 1'b1);
    push_one(4'd0, KIND_TEMP, -16'sd32768, 1'b0, 32'd1100, 1'b1);
    push_one(4'd0, KIND_TEMP, -16'sd32768, 1'b1, 32'd1101, 1'b1);
    push_one(4'd0, KIND_TEMP, -16'sd32568, 1'b0, 32'd1200, 1'b1);
    push_one(4'd0, KIND_HUM, 16'sd8000, 1'b0, 32'd1201, 1'b1);
    // two crossings in one batch, last one wins; device from the first reading
    push_one(4'd0, KIND_TEMP, 16'sd4000, 1'b0, $urandom, 1'b0);
    push_one(4'd9, KIND_HUM, 16'sd0, 1'b0, $urandom, 1'b0);
    push_one(4'd5, KIND_OTHER, 16'sd123, 1'b1, 32'd1202, 1'b1);
    // inside the hysteresis window, then spare kind with anomaly in holdoff
    push_one(4'd0, KIND_TEMP, 16'sd2960, 1'b0, 32'd1300, 1'b1);
    push_one(4'd0, KIND_SPARE, 16'sd0, 1'b1, 32'd1301, 1'b1);
    // time running backwards looks like a long gap
    push_one(4'd0, KIND_TEMP, 16'sd2960, 1'b1, 32'd5, 1'b1);
    // first report with no sensor kind seen
    push_one(4'd1, KIND_OTHER, -16'sd1, 1'b0, 32'd7, 1'b1);
    // holdoff across the 32-bit wrap
    push_one(4'd15, KIND_HUM, 16'sd32767, 1'b1, 32'hFFFF_FFFF, 1'b1);
    push_one(4'd15, KIND_HUM, 16'sd32767, 1'b1, 32'h0000_0010, 1'b1);
    // zero drift limits: no hysteresis, any value drifts
    set_config(1'b1, WARN_TEMP_RST, WARN_HUM_RST, 15'd0, 15'd0, 16'd0);
    push_one(4'd0, KIND_TEMP, 16'sd2960, 1'b0, 32'd20, 1'b1);
    push_one(4'd0, KIND_TEMP, 16'sd2960, 1'b0, 32'd21, 1'b1);
    // disable abandons an open batch
    push_one(4'd2, KIND_TEMP, 16'sd100, 1'b0, 32'd30, 1'b0);
    wait_quiet();
    write_reg(REG_ENABLE, 16'd0);
    push_one(4'd2, KIND_TEMP, 16'sd5000, 1'b1, 32'd31, 1'b1);
    wait_quiet();
    write_reg(REG_ENABLE, 16'd1);
    push_one(4'd3, KIND_HUM, -16'sd5, 1'b0, 32'd40, 1'b1);
    push_one(4'd2, KIND_TEMP, 16'sd0, 1'b0, 32'd41, 1'b1);

    // Random at reset defaults, both sides idling
    set_config(ENABLE_RST, WARN_TEMP_RST, WARN_HUM_RST,
               TEMP_DRIFT_RST, HUMIDITY_DRIFT_RST, HOLDOFF_RST);
    clock_now = 32'd2000;
    queue_batches(150, 4);

    // Extremes, no idling
    set_config(1'b1, 16'h8000, 16'h7FFF, 15'd0, 15'd0, 16'd0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    queue_batches(100, 4);

    // Opposite extremes, time close to wrap
    set_config(1'b1, 16'h7FFF, 16'h8000, 15'h7FFF, 15'h7FFF, 16'hFFFF);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    clock_now = 32'hFFFF_FFE0;
    queue_batches(100, 4);

    // Back pressure: receiver holds, sender streams single-reading batches
    set_config(1'b1, 16'($urandom), 16'($urandom), 15'($urandom_range(0, 300)),
               15'($urandom_range(0, 800)), 16'($urandom_range(0, 100)));
    tx_idle_on = 1'b0;
    pressure_go = 1'b1;
    queue_batches(60, 1);

    // Disabled stretch, then random settings
    set_config(1'b0, 16'($urandom), 16'($urandom), 15'($urandom_range(0, 300)),
               15'($urandom_range(0, 800)), 16'($urandom_range(0, 100)));
    tx_idle_on = 1'b1;
    queue_batches(30, 3);
    set_config(1'b1, 16'($urandom), 16'($urandom), 15'($urandom_range(0, 32767)),
               15'($urandom_range(0, 800)), 16'($urandom_range(0, 120)));
    queue_batches(150, 4);

    wait_quiet();
    repeat (8) @(negedge clk);
    $display("tb_top: %0d readings in, %0d register settings, %0d cycles",
             sent_cnt, cfg_changes, cycle_cnt);
    $display("tb_top: decisions silent %0d first %0d anomaly %0d rose %0d fell %0d drift %0d",
             tally[REASON_SILENT], tally[REASON_FIRST], tally[REASON_ANOMALY],
             tally[REASON_ROSE], tally[REASON_FELL], tally[REASON_DRIFT]);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
